// ----- design/usbin_pkg.sv -----
// Package for the USB IN endpoint packetizer: sizes, result and input codes,
// the controller state type and the FIFO RAM request struct.
// No dependencies.
`default_nettype none

package usbin_pkg;

  localparam int FIFO_DEPTH       = 512;
  localparam int MAX_PACKET_LIMIT = 64;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int RUN_W  = $clog2(FIFO_DEPTH + 2);

  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_ZLP   = 3'd1,
    KIND_DROP  = 3'd2,
    KIND_FAIL  = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_DONE  = 2'd1,
    MODE_SOF   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FAIL = 2'd1
  } status_t;

  localparam logic CFG_MAX_PACKET = 1'b0;
  localparam logic CFG_TX_ENABLED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- design/usbin_ifs.sv -----
// Channel interfaces of the USB IN endpoint packetizer: input items,
// result items and configuration writes. Depends on usbin_pkg.
`default_nettype none

interface usbin_in_if import usbin_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_write;
  logic [LEN_W-1:0]  done_length;
  logic [1:0]        done_status;

  modport source (output valid, mode, data_byte, end_of_write, done_length, done_status,
                  input ready);
  modport sink (input valid, mode, data_byte, end_of_write, done_length, done_status,
                output ready);
endinterface

interface usbin_out_if import usbin_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  info_length;
  logic              last;

  modport source (output valid, kind, out_byte, info_length, last, input ready);
  modport sink (input valid, kind, out_byte, info_length, last, output ready);
endinterface

interface usbin_cfg_if import usbin_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [LEN_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/usbin_fifo_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module usbin_fifo_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/usbin_ctrl.sv -----
// Packetizer sequencer: FIFO pointers and flags, endpoint state, packet
// emission through the FIFO RAM, result register and configuration.
// Depends on usbin_pkg and usbin_ifs.
`default_nettype none

module usbin_ctrl import usbin_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  usbin_in_if.sink               in_if,
  usbin_out_if.source            out_if,
  usbin_cfg_if.sink              cfg_if,
  output ram_req_t               ram_req,
  input  wire logic [BYTE_W-1:0] ram_rd_data
);

  localparam logic [LEN_W-1:0] MPS_LIMIT = LEN_W'(MAX_PACKET_LIMIT);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [RUN_W-1:0] RUN_SAT   = RUN_W'(FIFO_DEPTH);

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              idle_r, idle_nxt;
  logic              zlp_r, zlp_nxt;
  logic              armed_r, armed_nxt;
  logic [LEN_W-1:0]  max_packet_r, max_packet_nxt;
  logic              tx_en_r, tx_en_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  logic [LEN_W-1:0]  pend_len_r, pend_len_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LEN_W-1:0]  mps;
  logic              slot_free;

  function automatic logic [LEN_W-1:0] pkt_len(input logic [CNT_W-1:0] cnt,
                                               input logic tail,
                                               input logic [LEN_W-1:0] size);
    if (cnt >= CNT_W'(size)) begin
      return size;
    end else if (tail && cnt != '0) begin
      return LEN_W'(cnt);
    end
    return '0;
  endfunction

  assign mps = (max_packet_r == '0) ? LEN_W'(1) :
               (max_packet_r > MPS_LIMIT) ? MPS_LIMIT : max_packet_r;
  assign slot_free = !out_valid_r || out_if.ready;

  assign in_if.ready        = (state_r == ST_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.info_length = out_len_r;
  assign out_if.last        = out_last_r;

  always_comb begin
    logic             full;
    logic [CNT_W-1:0] cnt_new;
    logic [RUN_W-1:0] run_new;
    logic             fresh;
    logic             do_submit;
    logic             sub_tail;
    logic [CNT_W-1:0] sub_cnt;
    logic             from_done;
    logic             done_idle;
    logic [LEN_W-1:0] len;
    logic             go;

    state_nxt      = state_r;
    rptr_nxt       = rptr_r;
    wptr_nxt       = wptr_r;
    count_nxt      = count_r;
    run_nxt        = run_r;
    idle_nxt       = idle_r;
    zlp_nxt        = zlp_r;
    armed_nxt      = armed_r;
    max_packet_nxt = max_packet_r;
    tx_en_nxt      = tx_en_r;
    left_nxt       = left_r;
    plen_nxt       = plen_r;
    pend_kind_nxt  = pend_kind_r;
    pend_len_nxt   = pend_len_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_kind_nxt   = out_kind_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = wptr_r;
    ram_req.wr_data = in_if.data_byte;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = rptr_r;

    full      = (count_r == CNT_FULL);
    cnt_new   = count_r;
    run_new   = run_r;
    fresh     = 1'b0;
    do_submit = 1'b0;
    sub_tail  = 1'b0;
    sub_cnt   = count_r;
    from_done = 1'b0;
    done_idle = 1'b0;
    len       = '0;
    go        = 1'b0;

    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_MAX_PACKET: max_packet_nxt = cfg_if.data;
        CFG_TX_ENABLED: tx_en_nxt = cfg_if.data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          case (in_if.mode)
            MODE_WRITE: begin
              if (full) begin
                pend_kind_nxt = KIND_DROP;
                pend_len_nxt  = '0;
                state_nxt     = ST_SINGLE;
              end else begin
                ram_req.wr_en = 1'b1;
                wptr_nxt      = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
                cnt_new       = count_r + CNT_W'(1);
                run_new       = (run_r <= RUN_SAT) ? run_r + RUN_W'(1) : run_r;
                count_nxt     = cnt_new;
                run_nxt       = run_new;
              end
              if (in_if.end_of_write) begin
                run_nxt = '0;
                fresh   = (RUN_W'(cnt_new) == run_new);
                if (!full && (cnt_new >= CNT_W'(mps) || fresh) && idle_r && tx_en_r) begin
                  idle_nxt  = 1'b0;
                  do_submit = 1'b1;
                  sub_tail  = fresh;
                  sub_cnt   = cnt_new;
                end
              end
            end
            MODE_DONE: begin
              if (in_if.done_status != STAT_OK) begin
                if (in_if.done_status == STAT_FAIL) begin
                  pend_kind_nxt = KIND_FAIL;
                  pend_len_nxt  = in_if.done_length;
                  state_nxt     = ST_SINGLE;
                end
                idle_nxt = 1'b1;
              end else if (tx_en_r) begin
                do_submit = 1'b1;
                from_done = 1'b1;
              end else begin
                done_idle = 1'b1;
              end
            end
            MODE_SOF: begin
              if (idle_r) begin
                if (count_r == '0 && !zlp_r) begin
                  armed_nxt = 1'b0;
                end else if (!armed_r) begin
                  armed_nxt = 1'b1;
                end else if (tx_en_r) begin
                  idle_nxt  = 1'b0;
                  do_submit = 1'b1;
                  sub_tail  = 1'b1;
                end
              end
            end
            default: ;
          endcase

          if (do_submit) begin
            len = pkt_len(sub_cnt, sub_tail, mps);
            go  = (len != '0) || (sub_tail && zlp_r);
            if (go) begin
              zlp_nxt   = 1'b0;
              armed_nxt = 1'b0;
              if (len == '0) begin
                pend_kind_nxt = KIND_ZLP;
                pend_len_nxt  = '0;
                state_nxt     = ST_SINGLE;
              end else begin
                plen_nxt  = len;
                left_nxt  = len;
                state_nxt = ST_RD;
              end
            end else begin
              idle_nxt = 1'b1;
              if (from_done) begin
                done_idle = 1'b1;
              end
            end
          end

          if (done_idle) begin
            idle_nxt = 1'b1;
            if (count_r == '0) begin
              if (in_if.done_length == mps) begin
                zlp_nxt = 1'b1;
              end else begin
                pend_kind_nxt = KIND_EMPTY;
                pend_len_nxt  = '0;
                state_nxt     = ST_SINGLE;
              end
            end
          end
        end
      end
      ST_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_byte_nxt  = '0;
          out_len_nxt   = pend_len_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RD: begin
        ram_req.rd_en = 1'b1;
        rptr_nxt      = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
        count_nxt     = count_r - CNT_W'(1);
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BYTE;
          out_byte_nxt  = ram_rd_data;
          out_len_nxt   = plen_r;
          out_last_nxt  = (left_r == LEN_W'(1));
          left_nxt      = left_r - LEN_W'(1);
          state_nxt     = (left_r == LEN_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rptr_r       <= '0;
      wptr_r       <= '0;
      count_r      <= '0;
      run_r        <= '0;
      idle_r       <= 1'b1;
      zlp_r        <= 1'b0;
      armed_r      <= 1'b0;
      max_packet_r <= LEN_W'(64);
      tx_en_r      <= 1'b0;
      left_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rptr_r       <= rptr_nxt;
      wptr_r       <= wptr_nxt;
      count_r      <= count_nxt;
      run_r        <= run_nxt;
      idle_r       <= idle_nxt;
      zlp_r        <= zlp_nxt;
      armed_r      <= armed_nxt;
      max_packet_r <= max_packet_nxt;
      tx_en_r      <= tx_en_nxt;
      left_r       <= left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plen_r      <= plen_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_len_r  <= pend_len_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ----- design/usb_in_endpoint_packetizer_top.sv -----
// USB IN endpoint packetizer top level: sequencer plus byte FIFO RAM.
// An input item is taken only in the idle state; no new item is taken until its
// results have all been loaded into the result register. A packet is emitted with
// one RAM read and one result register load per byte, stalling while a result is held.
// Reset is synchronous: pointers, counts and flags clear; the RAM is not cleared.
// Depends on usbin_pkg, usbin_ifs, usbin_fifo_ram and usbin_ctrl.
`default_nettype none

module usb_in_endpoint_packetizer_top import usbin_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  usbin_in_if.sink    in_if,
  usbin_out_if.source out_if,
  usbin_cfg_if.sink   cfg_if
);

  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rd_data;

  usbin_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_if      (cfg_if),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  usbin_fifo_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

// ----- design/usbin_checker.sv -----
// Port-level assertions for the USB IN endpoint packetizer and the bind that
// attaches them to the top level. Depends on usbin_pkg.
`default_nettype none

module usbin_checker import usbin_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [2:0]       out_kind,
  input wire logic [LEN_W-1:0] out_info_length,
  input wire logic             out_last
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_info_length) && $stable(out_last))
    else $error("stalled result changed");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_last)
    else $error("non-byte result not marked last");

  a_byte_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE |->
    out_info_length != '0 && out_info_length <= LEN_W'(MAX_PACKET_LIMIT))
    else $error("packet byte with bad length");

  a_no_accept_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a packet is unfinished");

endmodule

bind usb_in_endpoint_packetizer_top usbin_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_kind        (out_if.kind),
  .out_info_length (out_if.info_length),
  .out_last        (out_if.last)
);

`default_nettype wire

// ----- tb/sv/usb_in_endpoint_packetizer_top_tb.sv -----
// Self-checking testbench for the USB IN endpoint packetizer: directed and random
// item streams with random stalls on both channels, checked against a packet scoreboard.
// Depends on usbin_pkg, usbin_ifs and usb_in_endpoint_packetizer_top.
`default_nettype none

import usbin_pkg::*;

typedef struct packed {
  logic [1:0]        mode;
  logic [BYTE_W-1:0] data;
  logic              eow;
  logic [LEN_W-1:0]  dlen;
  logic [1:0]        status;
} usb_item_t;

typedef struct packed {
  kind_t             kind;
  logic [BYTE_W-1:0] data;
  logic [LEN_W-1:0]  len;
  logic              last;
} usb_result_t;

class packet_scoreboard;
  logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  fill;
  logic [RUN_W-1:0]  run_len;
  logic [LEN_W-1:0]  max_packet;
  logic [LEN_W-1:0]  last_pkt_len;
  bit                ep_idle;
  bit                zlp_owed;
  bit                tail_armed;
  bit                tx_enabled;
  usb_result_t       step_q[$];
  usb_result_t       expected_q[$];
  int                errors;

  function new();
    rd_ptr = '0;
    wr_ptr = '0;
    fill = '0;
    run_len = '0;
    max_packet = LEN_W'(MAX_PACKET_LIMIT);
    last_pkt_len = '0;
    ep_idle = 1'b1;
    zlp_owed = 1'b0;
    tail_armed = 1'b0;
    tx_enabled = 1'b0;
    errors = 0;
  endfunction

  function int packet_limit();
    if (max_packet == 0) return 1;
    if (max_packet > MAX_PACKET_LIMIT) return MAX_PACKET_LIMIT;
    return int'(max_packet);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(input string msg);
    if (errors < 50) $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function void add(input kind_t k, input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] l);
    usb_result_t r;
    r.kind = k;
    r.data = d;
    r.len = l;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function logic [BYTE_W-1:0] pop_byte();
    logic [BYTE_W-1:0] b;
    b = fifo_mem[rd_ptr];
    rd_ptr = rd_ptr + 1'b1;
    fill = fill - 1'b1;
    return b;
  endfunction

  function bit send_packet(input bit tail);
    int m;
    int len;
    m = packet_limit();
    len = 0;
    if (fill >= m || (tail && fill > 0)) len = (fill < m) ? int'(fill) : m;
    if (len == 0 && !(tail && zlp_owed)) begin
      ep_idle = 1'b1;
      return 1'b0;
    end
    zlp_owed = 1'b0;
    tail_armed = 1'b0;
    last_pkt_len = LEN_W'(len);
    if (len == 0) begin
      add(KIND_ZLP, '0, '0);
    end else begin
      for (int i = 0; i < len; i++) add(KIND_BYTE, pop_byte(), LEN_W'(len));
    end
    return 1'b1;
  endfunction

  function void start_packet(input bit tail);
    if (!ep_idle || !tx_enabled) return;
    ep_idle = 1'b0;
    void'(send_packet(tail));
  endfunction

  function void write_reg(input logic idx, input logic [LEN_W-1:0] val);
    if (idx == CFG_MAX_PACKET) max_packet = val;
    else tx_enabled = val[0];
  endfunction

  function void note_input(input usb_item_t it);
    int m;
    int cnt;
    bit dropped;
    bit fresh;
    bit sent;
    usb_result_t r;
    m = packet_limit();
    step_q.delete();
    case (it.mode)
      MODE_WRITE: begin
        dropped = 1'b0;
        if (fill >= FIFO_DEPTH) begin
          dropped = 1'b1;
          add(KIND_DROP, '0, '0);
        end else begin
          fifo_mem[wr_ptr] = it.data;
          wr_ptr = wr_ptr + 1'b1;
          fill = fill + 1'b1;
          if (run_len <= FIFO_DEPTH) run_len = run_len + 1'b1;
        end
        if (it.eow) begin
          cnt = int'(run_len);
          run_len = '0;
          if (!dropped && cnt > 0) begin
            fresh = (fill == cnt);
            if (fill >= m || fresh) start_packet(fresh);
          end
        end
      end
      MODE_DONE: begin
        if (it.status != STAT_OK) begin
          if (it.status == STAT_FAIL) add(KIND_FAIL, '0, it.dlen);
          ep_idle = 1'b1;
        end else begin
          sent = tx_enabled ? send_packet(1'b0) : 1'b0;
          if (!sent) begin
            ep_idle = 1'b1;
            if (fill == 0) begin
              if (it.dlen == m) zlp_owed = 1'b1;
              else add(KIND_EMPTY, '0, '0);
            end
          end
        end
      end
      MODE_SOF: begin
        if (ep_idle) begin
          if (fill == 0 && !zlp_owed) tail_armed = 1'b0;
          else if (!tail_armed) tail_armed = 1'b1;
          else start_packet(1'b1);
        end
      end
      default: ;
    endcase
    foreach (step_q[i]) begin
      r = step_q[i];
      r.last = (i == step_q.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  task check_result(input kind_t k, input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] l,
                    input logic lst);
    usb_result_t e;
    string diff;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result kind %s byte %h length %0d", k.name(), d, l));
      return;
    end
    e = expected_q.pop_front();
    diff = "";
    if (k !== e.kind) diff = {diff, $sformatf(" kind %s/%s", k.name(), e.kind.name())};
    if (d !== e.data) diff = {diff, $sformatf(" byte %h/%h", d, e.data)};
    if (l !== e.len) diff = {diff, $sformatf(" length %0d/%0d", l, e.len)};
    if (lst !== e.last) diff = {diff, $sformatf(" last %b/%b", lst, e.last)};
    if (diff != "") report({"result got/expected:", diff});
  endtask
endclass

module usb_in_endpoint_packetizer_top_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * MAX_PACKET_LIMIT + 16;
  localparam int SEGMENT_ITEMS = 25;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] STAT_ABORT  = 2'd3;
  localparam logic [63:0] BYTE_PATTERN = 64'h00_55_AA_FF_01_80_7F_FE;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   cycle_cnt;
  int   bytes_left;
  packet_scoreboard sb;

  usbin_in_if  in_if();
  usbin_out_if out_if();
  usbin_cfg_if cfg_if();

  usb_in_endpoint_packetizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.kind, out_if.out_byte, out_if.info_length, out_if.last);
  end

  function automatic usb_item_t item(input logic [1:0] mode, input logic [BYTE_W-1:0] data,
                                     input logic eow, input logic [LEN_W-1:0] dlen,
                                     input logic [1:0] status);
    usb_item_t it;
    it.mode = mode;
    it.data = data;
    it.eow = eow;
    it.dlen = dlen;
    it.status = status;
    return it;
  endfunction

  task automatic send_item(input usb_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.data_byte    <= it.data;
    in_if.end_of_write <= it.eow;
    in_if.done_length  <= it.dlen;
    in_if.done_status  <= it.status;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic set_config(input logic [LEN_W-1:0] mp, input logic en);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_MAX_PACKET;
    cfg_if.data  <= mp;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(CFG_MAX_PACKET, mp);
    cfg_if.index <= CFG_TX_ENABLED;
    cfg_if.data  <= LEN_W'(en);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(CFG_TX_ENABLED, LEN_W'(en));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic make_item(output usb_item_t it);
    int m;
    int pick;
    m = sb.packet_limit();
    pick = $urandom_range(99);
    it.mode = 2'($urandom);
    it.data = 8'($urandom);
    it.eow = 1'($urandom);
    it.dlen = 7'($urandom);
    it.status = 2'($urandom);
    if (bytes_left > 0) begin
      if (pick < 4) begin
        it.mode = MODE_SOF;
      end else begin
        it.mode = MODE_WRITE;
        bytes_left--;
        it.eow = (bytes_left == 0);
      end
    end else if (pick < 6) begin
      // Noise: every field random, the unused mode included.
    end else if (!sb.ep_idle) begin
      it.mode = MODE_DONE;
      if (pick < 88) begin
        it.status = STAT_OK;
        it.dlen = sb.last_pkt_len;
      end else begin
        it.status = 2'($urandom_range(1, 3));
      end
    end else if (pick < 60) begin
      bytes_left = (pick < 20) ? 1 : $urandom_range(1, 2 * m + 2);
      it.mode = MODE_WRITE;
      bytes_left--;
      it.eow = (bytes_left == 0);
    end else if (pick < 85) begin
      it.mode = MODE_SOF;
    end else begin
      it.mode = MODE_DONE;
      it.status = STAT_OK;
      it.dlen = (pick < 92) ? LEN_W'(m) : LEN_W'($urandom_range(0, MAX_PACKET_LIMIT));
    end
  endtask

  task automatic run_segment(input logic [LEN_W-1:0] mp, input logic en);
    usb_item_t it;
    set_config(mp, en);
    repeat (SEGMENT_ITEMS) begin
      make_item(it);
      send_item(it);
    end
    while (bytes_left > 0) begin
      make_item(it);
      send_item(it);
    end
    settle();
  endtask

  // With transmit blocked, overrun the FIFO so that the final byte of the write
  // is dropped, then end one more write that has no accepted byte at all.
  task automatic fill_fifo();
    for (int i = 0; i < FIFO_DEPTH + 2; i++)
      send_item(item(MODE_WRITE, 8'($urandom), i == FIFO_DEPTH + 1, '0, STAT_OK));
    send_item(item(MODE_WRITE, 8'($urandom), 1'b1, '0, STAT_OK));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_WRITE;
    in_if.data_byte = '0;
    in_if.end_of_write = 1'b0;
    in_if.done_length = '0;
    in_if.done_status = STAT_OK;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MAX_PACKET;
    cfg_if.data = '0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    bytes_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_config(7'd8, 1'b1);
    send_item(item(MODE_WRITE, 8'hFF, 1'b1, '0, STAT_OK));
    send_item(item(MODE_DONE, 8'h00, 1'b0, 7'd1, STAT_OK));
    for (int i = 0; i < 8; i++)
      send_item(item(MODE_WRITE, BYTE_PATTERN[8*(7-i) +: 8], i == 7, '0, STAT_OK));
    send_item(item(MODE_DONE, 8'h00, 1'b0, 7'd8, STAT_OK));
    send_item(item(MODE_SOF, 8'h00, 1'b0, '0, STAT_OK));
    send_item(item(MODE_SOF, 8'h00, 1'b0, '0, STAT_OK));
    send_item(item(MODE_DONE, 8'h00, 1'b0, 7'd127, STAT_FAIL));
    send_item(item(MODE_DONE, 8'h00, 1'b0, 7'd64, STAT_ABORT));
    send_item(item(MODE_UNUSED, 8'hFF, 1'b1, 7'd127, STAT_ABORT));
    send_item(item(MODE_WRITE, 8'h12, 1'b0, '0, STAT_OK));
    send_item(item(MODE_WRITE, 8'h34, 1'b0, '0, STAT_OK));
    send_item(item(MODE_WRITE, 8'h80, 1'b1, '0, STAT_OK));
    send_item(item(MODE_DONE, 8'h00, 1'b0, 7'd3, STAT_OK));
    settle();

    src_idle_pct = 25;
    sink_idle_pct = 61;
    run_segment(7'd64, 1'b1);
    run_segment(7'd1, 1'b1);
    set_config(7'd64, 1'b0);
    fill_fifo();
    settle();
    run_segment(7'd64, 1'b1);

    src_idle_pct = 61;
    sink_idle_pct = 25;
    run_segment(7'd0, 1'b1);
    run_segment(7'd127, 1'b1);
    run_segment(7'd8, 1'b0);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_segment(7'd13, 1'b1);
    run_segment(7'd64, 1'b1);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/usbin_pkg.sv
design/usbin_ifs.sv
design/usbin_fifo_ram.sv
design/usbin_ctrl.sv
design/usb_in_endpoint_packetizer_top.sv
design/usbin_checker.sv
tb/sv/usb_in_endpoint_packetizer_top_tb.sv
